// ===== sv/aapc_pkg.sv =====
// ----------------------------------------------------------------------------
// aapc_pkg: shared constants for the ADC averaging and calibration block
// Field widths, register indexes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package aapc_pkg;

    // Fixed field widths of the channels.
    localparam int SAMPLE_W   = 12;
    localparam int AVG_W      = 12;
    localparam int VOLT_W     = 32;
    localparam int COEF_W     = 32;
    localparam int CNT_W      = 8;
    localparam int N_COEF     = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4       = 3'd5;

    // Reset values of the registers.
    localparam logic [CNT_W-1:0]         RST_SAMPLE_COUNT = 8'd100;
    localparam logic signed [COEF_W-1:0] RST_COEF_0 = -32'sd163196834;
    localparam logic signed [COEF_W-1:0] RST_COEF_1 = 32'sd217699577;
    localparam logic signed [COEF_W-1:0] RST_COEF_2 = -32'sd92019540;
    localparam logic signed [COEF_W-1:0] RST_COEF_3 = 32'sd18387367;
    localparam logic signed [COEF_W-1:0] RST_COEF_4 = -32'sd1369101;

    // Fixed-point format of the polynomial argument and coefficients.
    localparam int Q_FRAC     = 24;
    localparam int X_DIVISOR  = 1000;
    localparam int DIVISOR_W  = $clog2(X_DIVISOR + 1);

    // Defaults for the top-level parameters.
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== sv/aapc_if.sv =====
// ----------------------------------------------------------------------------
// aapc_if: stream channels of the ADC averaging and calibration block
// One channel carries raw samples in, the other carries results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface aapc_in_if;
    import aapc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface aapc_out_if;
    import aapc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [AVG_W-1:0]         average;
    logic signed [VOLT_W-1:0] voltage;
    logic                     in_range;

    modport source (output valid, output average, output voltage, output in_range,
                    input ready);
    modport sink   (input valid, input average, input voltage, input in_range,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/aapc_front.sv =====
// ----------------------------------------------------------------------------
// aapc_front: sample accumulator
// Adds samples into a running sum and hands each finished block to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aapc_front #(
    parameter int SAMPLE_BITS = aapc_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    aapc_in_if.sink                                            smp,
    input  wire logic [aapc_pkg::CNT_W-1:0]                    sample_count,
    input  wire logic                                          q_full,
    output logic                                               q_push,
    output logic [SAMPLE_BITS+2*aapc_pkg::CNT_W-1:0]           q_data
);
    import aapc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] need;
    logic [CNT_W:0]   taken_inc;
    logic [SUM_W-1:0] sum_add;
    logic             close;
    logic             accept;

    // A count of zero behaves as one.
    assign need      = (sample_count == '0) ? CNT_W'(1) : sample_count;
    assign taken_inc = {1'b0, taken_reg} + (CNT_W+1)'(1);
    assign close     = taken_inc >= {1'b0, need};
    assign sum_add   = sum_reg + SUM_W'(SAMPLE_BITS'(smp.sample));

    // Only a closing word needs room in the queue.
    assign smp.ready = !close || !q_full;
    assign accept    = smp.valid && smp.ready;
    assign q_push    = accept && close;
    assign q_data    = {taken_inc[CNT_W-1:0], sum_add};

    always_comb
    begin
        taken_next = taken_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            if (close)
            begin
                taken_next = '0;
                sum_next   = '0;
            end
            else
            begin
                taken_next = taken_inc[CNT_W-1:0];
                sum_next   = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
        end
    end

`ifndef SYNTH
    a_close_clears : assert property (@(posedge clk) disable iff (!rst_n)
        accept && close |=> taken_reg == '0 && sum_reg == '0)
        else $error("accumulator not cleared after a closing word");
`endif

endmodule

`default_nettype wire

// ===== sv/aapc_queue.sv =====
// ----------------------------------------------------------------------------
// aapc_queue: short job queue
// Holds finished sums and counts between the accumulator and the math unit.
// ----------------------------------------------------------------------------
`default_nettype none

module aapc_queue #(
    parameter int W     = 28,
    parameter int DEPTH = aapc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              pop_valid,
    output logic [W-1:0]      pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== sv/aapc_back.sv =====
// ----------------------------------------------------------------------------
// aapc_back: averaging divider and polynomial evaluator
// Divides each job, scales the average and runs Horner's rule into a
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aapc_back #(
    parameter int SAMPLE_BITS = aapc_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                                clk,
    input  wire logic                                                rst_n,
    input  wire logic                                                job_valid,
    input  wire logic [SAMPLE_BITS+2*aapc_pkg::CNT_W-1:0]            job_data,
    output logic                                                     job_pop,
    input  wire logic [aapc_pkg::N_COEF-1:0][aapc_pkg::COEF_W-1:0]   coef,
    aapc_out_if.source                                               res
);
    import aapc_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DIVD_W = SAMPLE_BITS + Q_FRAC;
    localparam int XW     = DIVD_W - $clog2(X_DIVISOR) + 1;
    localparam int ITER_W = $clog2(SUM_W + 1);
    localparam int PROD_W = COEF_W + XW + 1;
    localparam int SHF_W  = PROD_W - Q_FRAC;
    localparam int ADD_W  = SHF_W + 1;
    localparam int K_W    = $clog2(N_COEF);

    // The argument avg * 2^24 / 1000 splits into an integer multiple of the
    // average plus floor(avg * X_REM / 1000). The second part uses a
    // reciprocal multiply that is exact for every product below 2^24, which
    // covers sample widths up to 16 bits.
    localparam longint unsigned X_INT   = (64'd1 << Q_FRAC) / X_DIVISOR;
    localparam longint unsigned X_REM   = (64'd1 << Q_FRAC) % X_DIVISOR;
    localparam int              RCP_SH  = 34;
    localparam longint unsigned RCP_MUL = ((64'd1 << RCP_SH) + X_DIVISOR - 1) / X_DIVISOR;
    localparam int XI_W  = $clog2(X_INT + 1);
    localparam int RCP_W = RCP_SH - $clog2(X_DIVISOR) + 1;
    localparam int XB_W  = SAMPLE_BITS + XI_W;
    localparam int XN_W  = SAMPLE_BITS + DIVISOR_W;
    localparam int XP_W  = XN_W + RCP_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_AVG = 3'd1;
    localparam logic [2:0] ST_SCALE   = 3'd2;
    localparam logic [2:0] ST_MUL     = 3'd3;
    localparam logic [2:0] ST_ADD     = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;
    localparam logic [2:0] ST_ARG     = 3'd6;

    localparam logic signed [ADD_W-1:0] SAT_MAX =
        {{(ADD_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SAT_MIN =
        {{(ADD_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};

    logic [2:0]                state_reg, state_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic [SUM_W-1:0]          quo_reg, quo_next;
    logic [DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [DIVISOR_W-1:0]      dvs_reg, dvs_next;
    logic [SAMPLE_BITS-1:0]    avg_reg, avg_next;
    logic [XB_W-1:0]           xb_reg, xb_next;
    logic [XN_W-1:0]           xn_reg, xn_next;
    logic [XW-1:0]             x_reg, x_next;
    logic signed [COEF_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic                      range_reg, range_next;
    logic                      ov_reg, ov_next;
    logic [AVG_W-1:0]          oavg_reg, oavg_next;
    logic signed [VOLT_W-1:0]  ovolt_reg, ovolt_next;
    logic                      orange_reg, orange_next;

    logic [SUM_W-1:0]          job_sum;
    logic [CNT_W-1:0]          job_cnt;
    logic [DIVISOR_W:0]        rem_sh;
    logic                      ge;
    logic [DIVISOR_W-1:0]      rem_new;
    logic [SUM_W-1:0]          quo_new;
    logic [SAMPLE_BITS-1:0]    avg_q;
    logic [XP_W-1:0]           xp;
    logic [XW-1:0]             x_arg;
    logic signed [SHF_W-1:0]   shf;
    logic signed [ADD_W-1:0]   add_w;
    logic signed [COEF_W-1:0]  sat_w;
    logic signed [COEF_W-1:0]  coef_sel;

    assign job_sum = job_data[SUM_W-1:0];
    assign job_cnt = job_data[SUM_W+CNT_W-1:SUM_W];

    // One restoring division step per cycle.
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_new = ge ? DIVISOR_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIVISOR_W-1:0];
    assign quo_new = {quo_reg[SUM_W-2:0], ge};
    assign avg_q   = quo_new[SAMPLE_BITS-1:0];

    // Argument: integer part plus the reciprocal-scaled fraction part.
    assign xp    = XP_W'(xn_reg) * XP_W'(RCP_MUL);
    assign x_arg = XW'(xb_reg) + XW'(xp[XP_W-1:RCP_SH]);

    // Horner add: floor shift of the product, add the coefficient, saturate.
    assign coef_sel = $signed(coef[k_reg]);
    assign shf      = $signed(prod_reg[PROD_W-1:Q_FRAC]);
    assign add_w    = ADD_W'(shf) + ADD_W'(coef_sel);
    assign sat_w    = (add_w > SAT_MAX) ? SAT_MAX[COEF_W-1:0] :
                      (add_w < SAT_MIN) ? SAT_MIN[COEF_W-1:0] :
                      add_w[COEF_W-1:0];

    assign job_pop = (state_reg == ST_IDLE) && job_valid;

    always_comb
    begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        avg_next    = avg_reg;
        xb_next     = xb_reg;
        xn_next     = xn_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        k_next      = k_reg;
        range_next  = range_reg;
        ov_next     = ov_reg && !res.ready;
        oavg_next   = oavg_reg;
        ovolt_next  = ovolt_reg;
        orange_next = orange_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    quo_next   = job_sum;
                    rem_next   = '0;
                    dvs_next   = DIVISOR_W'(job_cnt);
                    iter_next  = '0;
                    state_next = ST_DIV_AVG;
                end
            end
            ST_DIV_AVG:
            begin
                quo_next  = quo_new;
                rem_next  = rem_new;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(SUM_W - 1))
                begin
                    avg_next = avg_q;
                    if (avg_q == '0)
                    begin
                        range_next = 1'b0;
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        range_next = 1'b1;
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                xb_next    = XB_W'(avg_reg) * XB_W'(X_INT);
                xn_next    = XN_W'(avg_reg) * XN_W'(X_REM);
                state_next = ST_ARG;
            end
            ST_ARG:
            begin
                x_next     = x_arg;
                acc_next   = $signed(coef[N_COEF-1]);
                k_next     = K_W'(N_COEF - 2);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = acc_reg * $signed({1'b0, x_reg});
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = sat_w;
                if (k_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg - K_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next     = 1'b1;
                    oavg_next   = AVG_W'(avg_reg);
                    ovolt_next  = acc_reg;
                    orange_next = range_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg   <= iter_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        avg_reg    <= avg_next;
        xb_reg     <= xb_next;
        xn_reg     <= xn_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        k_reg      <= k_next;
        range_reg  <= range_next;
        oavg_reg   <= oavg_next;
        ovolt_reg  <= ovolt_next;
        orange_reg <= orange_next;
    end

    assign res.valid    = ov_reg;
    assign res.average  = oavg_reg;
    assign res.voltage  = ovolt_reg;
    assign res.in_range = orange_reg;

`ifndef SYNTH
    a_load_from_done : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside the finishing state");
    a_zero_when_out : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.in_range |-> res.voltage == '0)
        else $error("out-of-range word carries a nonzero voltage");
    a_mul_then_add : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_ADD)
        else $error("multiply not followed by its add step");
`endif

endmodule

`default_nettype wire

// ===== sv/adc_average_poly_calibrate.sv =====
// ----------------------------------------------------------------------------
// adc_average_poly_calibrate: ADC sample averaging with polynomial calibration
// Averages blocks of converter samples and turns each average into a
// calibrated Q8.24 voltage with a fourth-order polynomial.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                           Handshake
//  samples   in   sample[11:0]                      valid / ready
//  results   out  average[11:0], voltage[31:0],     valid / ready
//                 in_range
//  cfg       in   cfg_index[2:0], cfg_data[31:0]    cfg_we, no back-pressure
//
// A sample word that does not close a block is always taken; a closing word
// is taken as long as the job queue has room.
// For each job the math unit runs SAMPLE_BITS+8 divider steps for the average,
// scales it into the Q4.24 argument with a constant multiply and a reciprocal
// multiply, then takes a multiply and an add for each Horner step and ends in
// a hand-off state; an average of zero goes from the divider straight to the
// hand-off. The divider that forms the average is bit-serial and restoring.
// Reset clears the accumulator, the queue and the result valid flag; the
// registers return to their default calibration. A stalled result word
// holds in its register; the math unit then waits in its final state and the
// accumulator keeps taking words until a closing word finds the queue full.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_poly_calibrate #(
    parameter int SAMPLE_BITS = aapc_pkg::DEF_SAMPLE_BITS,
    parameter int QUEUE_DEPTH = aapc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    aapc_in_if.sink                                 samples,
    aapc_out_if.source                              results,
    input  wire logic                               cfg_we,
    input  wire logic [aapc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aapc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import aapc_pkg::*;

    localparam int JOB_W = SAMPLE_BITS + 2 * CNT_W;

    // Configuration registers.
    logic [CNT_W-1:0]                  sample_count_reg, sample_count_next;
    logic [N_COEF-1:0][COEF_W-1:0]     coef_reg, coef_next;

    logic             q_push;
    logic [JOB_W-1:0] q_data;
    logic             q_full;
    logic             job_pop;
    logic             job_valid;
    logic [JOB_W-1:0] job_data;

    // Writes to an index past the last register are dropped.
    always_comb
    begin
        sample_count_next = sample_count_reg;
        coef_next         = coef_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_next = cfg_data[CNT_W-1:0];
                REG_COEF_0:       coef_next[0]      = cfg_data[COEF_W-1:0];
                REG_COEF_1:       coef_next[1]      = cfg_data[COEF_W-1:0];
                REG_COEF_2:       coef_next[2]      = cfg_data[COEF_W-1:0];
                REG_COEF_3:       coef_next[3]      = cfg_data[COEF_W-1:0];
                REG_COEF_4:       coef_next[4]      = cfg_data[COEF_W-1:0];
                default:          sample_count_next = sample_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= RST_SAMPLE_COUNT;
            coef_reg[0]      <= RST_COEF_0;
            coef_reg[1]      <= RST_COEF_1;
            coef_reg[2]      <= RST_COEF_2;
            coef_reg[3]      <= RST_COEF_3;
            coef_reg[4]      <= RST_COEF_4;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            coef_reg         <= coef_next;
        end
    end

    // Front: accumulates samples and emits one job per finished block.
    aapc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .smp          (samples),
        .sample_count (sample_count_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    // Queue: lets the accumulator run on while the math unit is busy.
    aapc_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (job_pop),
        .pop_valid (job_valid),
        .pop_data  (job_data)
    );

    // Back: divider, argument scaling and Horner evaluation.
    aapc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .coef      (coef_reg),
        .res       (results)
    );

endmodule

`default_nettype wire

// ===== dv/tb_adc_average_poly_calibrate.sv =====
// ----------------------------------------------------------------------------
// tb_adc_average_poly_calibrate: self-checking bench for the averaging block
// Sends converter sample words through the input channel and checks every
// result word against a bit-exact calibration predictor kept in the bench.
// A directed table covers the field extremes and the corner cases. Random
// phases then follow, under several block sizes and calibration sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adc_average_poly_calibrate;
    import aapc_pkg::*;

    // Timing of the run. SETTLE_CYCLES comfortably covers one job in the math
    // unit plus the queue hand-off.
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 400_000;

    // One result word as the block presents it.
    typedef struct packed {
        logic [AVG_W-1:0]         average;
        logic signed [VOLT_W-1:0] voltage;
        logic                     in_range;
    } result_t;

    localparam result_t NO_RESULT = '0;

    // Rows of the directed table: either a register write or a sample word.
    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

    typedef struct packed {
        row_kind_e               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   value;
        logic                    typed;
        result_t                 want;
    } stim_row_t;

    // Ways the random phases pick a calibration set.
    typedef enum int {CAL_RESET, CAL_FULL, CAL_MODEST, CAL_EXTREME} cal_mode_e;

    localparam logic [COEF_W-1:0] RESET_CAL [N_COEF] = '{
        RST_COEF_0, RST_COEF_1, RST_COEF_2, RST_COEF_3, RST_COEF_4
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aapc_in_if  samples_ch ();
    aapc_out_if results_ch ();

    adc_average_poly_calibrate DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the calibration registers and of the accumulator state.
    logic [CNT_W-1:0]         cal_count;
    logic signed [COEF_W-1:0] cal_coef [N_COEF];
    int unsigned              acc_sum;
    int unsigned              acc_taken;

    // Result words still owed by the block, oldest first.
    result_t   pending_results [$];
    stim_row_t stim_rows [$];

    int  mismatches;
    int  cycle_count;
    bit  quiet_tail;
    bit  hold_off_request;

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Evaluates the quartic in x = avg / 1000 (Q4.24) by Horner's rule. Each
    // product drops its 24 fraction bits toward minus infinity, and each sum
    // saturates to the signed 32-bit range before the next step.
    function automatic logic signed [VOLT_W-1:0] calib_voltage(input logic [AVG_W-1:0] avg);
        longint x;
        longint acc;
        x   = (longint'(avg) << Q_FRAC) / X_DIVISOR;
        acc = longint'(cal_coef[N_COEF-1]);
        for (int k = N_COEF - 2; k >= 0; k--)
        begin
            acc = ((acc * x) >>> Q_FRAC) + longint'(cal_coef[k]);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            else if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
        end
        return acc[VOLT_W-1:0];
    endfunction

    // Adds one sample word into the mirrored accumulator. Returns 1 when the
    // word closes a block, with the result word the block must produce.
    function automatic bit predict_sample(input logic [SAMPLE_W-1:0] s, output result_t r);
        int unsigned need;
        int unsigned avg;
        r    = NO_RESULT;
        // A block size of zero behaves like one.
        need = (cal_count == 0) ? 1 : cal_count;
        acc_sum   += s;
        acc_taken  = (acc_taken + 1) & 8'hFF;
        // The count is compared with >=, so a size lowered in the middle of a
        // block closes it on the next word.
        if (acc_taken != 0 && acc_taken < need)
            return 1'b0;
        if (acc_taken == 0)
            acc_taken = 256;
        avg       = acc_sum / acc_taken;
        acc_sum   = 0;
        acc_taken = 0;
        r.average = avg[AVG_W-1:0];
        // An average of zero is out of range and reports a voltage of zero.
        if (avg != 0)
        begin
            r.voltage  = calib_voltage(avg[AVG_W-1:0]);
            r.in_range = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = val;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_sample(input logic [SAMPLE_W-1:0] s);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.value = CFG_DATA_W'(s);
        stim_rows.push_back(r);
    endfunction

    // A sample word whose result word is obvious enough to write down.
    function automatic void add_typed(input logic [SAMPLE_W-1:0] s, input logic [AVG_W-1:0] avg,
                                      input logic [VOLT_W-1:0] volt, input logic inr);
        stim_row_t r;
        r                = '0;
        r.kind           = ROW_SAMPLE;
        r.value          = CFG_DATA_W'(s);
        r.typed          = 1'b1;
        r.want.average   = avg;
        r.want.voltage   = volt;
        r.want.in_range  = inr;
        stim_rows.push_back(r);
    endfunction

    // Random sample word: mostly uniform, with zeros, full scale and tiny
    // values mixed in so that averages of zero and one come up.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit high_bias);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 3));
            default: return high_bias ? SAMPLE_W'($urandom_range(3800, 4095))
                                      : SAMPLE_W'($urandom);
        endcase
    endfunction

    // Register writes happen at a rising edge with cfg_we high; the mirror is
    // updated once the write has gone in.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SAMPLE_COUNT)
            cal_count = val[CNT_W-1:0];
        else if (idx >= REG_COEF_0 && idx <= REG_COEF_4)
            cal_coef[idx - REG_COEF_0] = val;
    endtask

    task automatic load_calibration(input cal_mode_e mode);
        logic [COEF_W-1:0] c;
        for (int k = 0; k < N_COEF; k++)
        begin
            case (mode)
                CAL_RESET:  c = RESET_CAL[k];
                CAL_FULL:   c = $urandom;
                // Coefficients within +-4 give moderate values that only
                // sometimes reach the rails.
                CAL_MODEST: c = COEF_W'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       c = 32'h7FFF_FFFF;
                        1:       c = 32'h8000_0000;
                        default: c = '0;
                    endcase
                end
            endcase
            cfg_write(CFG_IDX_W'(REG_COEF_0 + k), c);
        end
    endtask

    // Drops valid and waits until every owed result word has come back,
    // then lets the block settle so that it is idle for register writes.
    task automatic drain_results();
        @(negedge clk);
        samples_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one sample word, possibly after a random gap, and waits for the
    // handshake. The word is only handed to the predictor once accepted.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input result_t want);
        result_t predicted;
        int      gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            samples_ch.valid  <= 1'b0;
            samples_ch.sample <= SAMPLE_W'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        if (predict_sample(s, predicted))
            pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: random stall bursts, one long hold-off on request so that
    // the job queue fills and the input stalls, and none in the quiet tail.
    initial
    begin
        int stall_left;
        stall_left        = 0;
        results_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                results_ch.ready <= 1'b0;
            end
            else if (hold_off_request)
            begin
                hold_off_request  = 1'b0;
                stall_left        = HOLD_OFF_CYCLES - 1;
                results_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left        = $urandom_range(1, 9) - 1;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                results_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted result word is checked field by field against the
    // oldest owed word.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word with none owed: average %0d, voltage %0d, in_range %0d",
                         $time, results_ch.average, results_ch.voltage, results_ch.in_range);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (results_ch.average !== want.average)
                begin
                    $display("%0t ns: average mismatch: expected %0d, actual %0d",
                             $time, want.average, results_ch.average);
                    mismatches++;
                end
                if (results_ch.voltage !== want.voltage)
                begin
                    $display("%0t ns: voltage mismatch: expected %0d, actual %0d",
                             $time, want.voltage, results_ch.voltage);
                    mismatches++;
                end
                if (results_ch.in_range !== want.in_range)
                begin
                    $display("%0t ns: in_range mismatch: expected %0d, actual %0d",
                             $time, want.in_range, results_ch.in_range);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n;
        mismatches        = 0;
        cycle_count       = 0;
        quiet_tail        = 1'b0;
        hold_off_request  = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;

        // The mirror starts from the reset calibration and an empty block.
        cal_count = RST_SAMPLE_COUNT;
        for (int k = 0; k < N_COEF; k++)
            cal_coef[k] = RESET_CAL[k];
        acc_sum   = 0;
        acc_taken = 0;

        // Directed table. One-word blocks first, under the reset calibration:
        // a zero word is out of range, then the lowest in-range average and
        // full scale.
        add_cfg(REG_SAMPLE_COUNT, 32'd1);
        add_typed(12'd0, 12'd0, 32'd0, 1'b0);
        add_sample(12'd1);
        add_sample(12'hFFF);
        add_sample(12'h800);
        add_sample(12'hAAA);
        add_sample(12'h555);
        // A block size of zero still closes on every word.
        add_cfg(REG_SAMPLE_COUNT, 32'd0);
        add_sample(12'hFFF);
        add_typed(12'd0, 12'd0, 32'd0, 1'b0);
        // With every term but the constant at zero the voltage is the
        // constant itself, at both ends of its range.
        add_cfg(REG_COEF_0, 32'h7FFF_FFFF);
        for (int k = 1; k < N_COEF; k++)
            add_cfg(CFG_IDX_W'(REG_COEF_0 + k), 32'd0);
        add_typed(12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1'b1);
        add_cfg(REG_COEF_0, 32'h8000_0000);
        add_typed(12'd1, 12'd1, 32'h8000_0000, 1'b1);
        // All terms at the positive and then the negative rail saturate.
        for (int k = 0; k < N_COEF; k++)
            add_cfg(CFG_IDX_W'(REG_COEF_0 + k), 32'h7FFF_FFFF);
        add_sample(12'hFFF);
        for (int k = 0; k < N_COEF; k++)
            add_cfg(CFG_IDX_W'(REG_COEF_0 + k), 32'h8000_0000);
        add_sample(12'hFFF);
        // A tiny negative quartic term shows the rounding toward minus infinity.
        for (int k = 0; k < N_COEF - 1; k++)
            add_cfg(CFG_IDX_W'(REG_COEF_0 + k), 32'd0);
        add_cfg(REG_COEF_4, 32'hFFFF_FFFF);
        add_sample(12'd3);
        // A mean below one truncates to an average of zero.
        add_cfg(REG_SAMPLE_COUNT, 32'd4);
        add_sample(12'd1);
        add_sample(12'd2);
        add_sample(12'd0);
        add_typed(12'd0, 12'd0, 32'd0, 1'b0);
        // The block size is lowered while a block is half collected: the next
        // word closes it and the mean covers all six words.
        add_cfg(REG_SAMPLE_COUNT, 32'd10);
        repeat (5) add_sample(12'd7);
        add_cfg(REG_SAMPLE_COUNT, 32'd3);
        add_sample(12'd9);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                drain_results();
                cfg_write(stim_rows[i].reg_idx, stim_rows[i].value);
            end
            else
            begin
                send_sample(stim_rows[i].value[SAMPLE_W-1:0], stim_rows[i].typed,
                            stim_rows[i].want);
            end
        end

        // Default calibration at the default block size: large running sums.
        drain_results();
        cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(RST_SAMPLE_COUNT));
        load_calibration(CAL_RESET);
        repeat (100) send_sample(pick_sample(1'b0), 1'b0, NO_RESULT);

        // Largest block with words near full scale brings the sum to its top.
        drain_results();
        cfg_write(REG_SAMPLE_COUNT, 32'd255);
        load_calibration(cal_mode_e'($urandom_range(0, 3)));
        repeat (255) send_sample(pick_sample(1'b1), 1'b0, NO_RESULT);

        // One-word blocks while the result side holds off for a long stretch:
        // the job queue fills and the input channel stalls.
        drain_results();
        cfg_write(REG_SAMPLE_COUNT, 32'd1);
        load_calibration(CAL_MODEST);
        hold_off_request = 1'b1;
        repeat (30) send_sample(pick_sample(1'b0), 1'b0, NO_RESULT);

        // Random phases with small blocks and varied calibration sets. The
        // last three run without gaps or stalls on either side.
        for (int phase = 0; phase < 12; phase++)
        begin
            drain_results();
            quiet_tail = (phase >= 9);
            case ($urandom_range(0, 7))
                0:       n = 0;
                1:       n = 1;
                default: n = $urandom_range(2, 8);
            endcase
            cfg_write(REG_SAMPLE_COUNT, CFG_DATA_W'(n));
            load_calibration(cal_mode_e'($urandom_range(0, 3)));
            repeat (25) send_sample(pick_sample(1'b0), 1'b0, NO_RESULT);
        end

        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
